// ===== src/row_run_line_tracker_unit_defines.svh =====
// Assertion macros for the checker file of the row run line tracker.
// No dependencies; included by name from the checker file that asserts.
`ifndef ROW_RUN_LINE_TRACKER_UNIT_DEFINES_SVH
`define ROW_RUN_LINE_TRACKER_UNIT_DEFINES_SVH

// Condition a must bring condition c in the same cycle.
`define RRLT_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rrlt: same-cycle check failed");

// Condition a must bring condition c in the next cycle.
`define RRLT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rrlt: next-cycle check failed");

`endif

// ===== src/rrlt_pkg.sv =====
// Package of the row run line tracker: payload and event types, register
// indexes, reset values and fixed constants. No dependencies.
package rrlt_pkg;

  localparam int MAX_COLS = 1024;
  localparam logic [9:0] COL_LAST = 10'(MAX_COLS - 1);

  localparam logic [7:0] LINE_LEVEL = 8'd127;
  localparam logic [9:0] MIN_RUN_WIDTH = 10'd5;
  localparam logic signed [31:0] ROUND_Q14 = 32'sd8192;
  localparam logic [19:0] DIST_NONE = 20'hFFFFF;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes.
  localparam logic [2:0] CFG_IMAGE_WIDTH      = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [2:0] CFG_BORDER_MARGIN    = 3'd2;
  localparam logic [2:0] CFG_MAX_RUN_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_TRACKING_ON      = 3'd4;
  localparam logic [2:0] CFG_TRACK_CENTER_Q4  = 3'd5;
  localparam logic [2:0] CFG_TRACK_SLOPE_Q14  = 3'd6;
  localparam logic [2:0] CFG_TRACK_DIST_LIMIT = 3'd7;

  // Register reset values.
  localparam logic [10:0] RST_IMAGE_WIDTH = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [7:0] RST_BORDER_MARGIN = 8'd15;
  localparam logic [9:0] RST_MAX_RUN_WIDTH = 10'd288;
  localparam logic RST_TRACKING_ON = 1'b0;
  localparam logic signed [15:0] RST_TRACK_CENTER_Q4 = -16'sd16;
  localparam logic signed [15:0] RST_TRACK_SLOPE_Q14 = 16'sd0;
  localparam logic [10:0] RST_TRACK_DIST_LIMIT = 11'd150;

  typedef struct packed {
    logic [7:0] pixel;
    logic [9:0] row;
    logic       last_in_row;
  } pix_t;

  typedef struct packed {
    logic        found;
    logic [10:0] center_x2;
    logic [9:0]  run_width;
    logic [9:0]  row_out;
  } res_t;

  typedef struct packed {
    logic [10:0]        image_width;
    logic [10:0]        image_height;
    logic [7:0]         border_margin;
    logic [9:0]         max_run_width;
    logic               tracking_on;
    logic signed [15:0] track_center_q4;
    logic signed [15:0] track_slope_q14;
    logic [10:0]        track_dist_limit;
  } cfg_t;

  // One closed run and/or a row end, handed from the front to the back.
  typedef struct packed {
    logic               has_run;
    logic [9:0]         run_start;
    logic [9:0]         run_end;
    logic               last;
    logic [9:0]         row;
    logic signed [15:0] dy_q4;
  } event_t;

endpackage

// ===== src/rrlt_front.sv =====
// Front of the row run line tracker: border mask, run detection and event
// generation, one pixel per cycle when not stalled. Depends on rrlt_pkg.
module rrlt_front (
  input  logic            clk,
  input  logic            rst,
  input  rrlt_pkg::cfg_t  cfg,
  input  logic            pix_valid,
  output logic            pix_stall,
  input  rrlt_pkg::pix_t  pix,
  input  logic            q_full,
  output logic            push,
  output rrlt_pkg::event_t push_event
);

  logic [9:0] column_count;
  logic [9:0] run_start;
  logic run_open;
  logic signed [15:0] dy_row;

  logic accept;
  logic [9:0] half_w, half_h;
  logic [7:0] mx, my;
  logic masked, line, close_now;
  logic signed [15:0] dy_now;

  assign pix_stall = q_full;
  assign accept = pix_valid && !pix_stall;

  always_comb begin
    half_w = (cfg.image_width[10:1] == 10'd0) ? 10'd0 : cfg.image_width[10:1] - 10'd1;
    half_h = (cfg.image_height[10:1] == 10'd0) ? 10'd0 : cfg.image_height[10:1] - 10'd1;
    mx = ({2'b00, cfg.border_margin} < half_w) ? cfg.border_margin : half_w[7:0];
    my = ({2'b00, cfg.border_margin} < half_h) ? cfg.border_margin : half_h[7:0];
    masked = (column_count < {2'b00, mx}) ||
             ({1'b0, column_count} >= cfg.image_width - {3'b000, mx}) ||
             (pix.row < {2'b00, my}) ||
             ({1'b0, pix.row} >= cfg.image_height - {3'b000, my});
    line = !masked && (pix.pixel > rrlt_pkg::LINE_LEVEL);
    close_now = !line && run_open;
    dy_now = $signed({2'b00, pix.row, 4'b0000}) - $signed({2'b00, cfg.image_height, 3'b000});

    push_event.last = pix.last_in_row;
    push_event.row = pix.row;
    push_event.dy_q4 = (column_count == 10'd0) ? dy_now : dy_row;
    if (close_now) begin
      push_event.has_run = column_count > run_start;
      push_event.run_start = run_start;
      push_event.run_end = column_count - 10'd1;
    end else begin
      // A run still open at the row end closes at this column.
      push_event.has_run = line;
      push_event.run_start = run_open ? run_start : column_count;
      push_event.run_end = column_count;
    end
    push = accept && (close_now || pix.last_in_row);
  end

  always_ff @(posedge clk) begin
    if (accept && column_count == 10'd0) begin
      dy_row <= dy_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 10'd0;
      run_open <= 1'b0;
      run_start <= 10'd0;
    end else if (accept) begin
      if (pix.last_in_row) begin
        column_count <= 10'd0;
        run_open <= 1'b0;
        run_start <= 10'd0;
      end else begin
        if (column_count < rrlt_pkg::COL_LAST) begin
          column_count <= column_count + 10'd1;
        end
        run_open <= line;
        if (line && !run_open) begin
          run_start <= column_count;
        end
      end
    end
  end

endmodule

// ===== src/rrlt_queue.sv =====
// Short event queue between the front and the back of the tracker.
// Depends on rrlt_pkg for the event type and depth.
module rrlt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrlt_pkg::event_t push_event,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output rrlt_pkg::event_t head
);

  rrlt_pkg::event_t slots [rrlt_pkg::QDEPTH];
  logic [rrlt_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [rrlt_pkg::QCNT_W-1:0] count;

  assign full = count == rrlt_pkg::QCNT_W'(rrlt_pkg::QDEPTH);
  assign not_empty = count != '0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rrlt_back.sv =====
// Back of the tracker: expected centre, run gating and best-run selection
// in stages that end in the result register. Depends on rrlt_pkg.
module rrlt_back (
  input  logic             clk,
  input  logic             rst,
  input  rrlt_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  rrlt_pkg::event_t q_event,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_stall,
  output rrlt_pkg::res_t   res
);

  logic en;

  // Stage 1: slope product.
  logic v1;
  rrlt_pkg::event_t e1;
  logic signed [31:0] prod1;

  // Stage 2: expected centre and width check.
  logic v2, ok2, last2;
  logic [10:0] c2_2;
  logic [9:0] w2, row2;
  logic signed [19:0] exp2;

  // Stage 3: distance and gate.
  logic v3, ok3, last3;
  logic [10:0] c2_3;
  logic [9:0] w3, row3;
  logic [19:0] d3;

  // Best run of the current row.
  logic best_valid;
  logic [10:0] best_center2;
  logic [9:0] best_width;
  logic [19:0] best_distance_q4;

  logic signed [31:0] rounded;
  logic signed [17:0] off;
  logic signed [19:0] exp_n;
  logic [9:0] w_n;
  logic [10:0] c2_n;
  logic signed [20:0] diff;
  logic [20:0] mag;
  logic take, nb_valid;
  logic [10:0] nb_center2;
  logic [9:0] nb_width;

  assign en = !res_valid || !res_stall;
  assign q_pop = en && q_valid;

  always_comb begin
    rounded = prod1 + rrlt_pkg::ROUND_Q14;
    off = rounded[31:14];
    exp_n = cfg.tracking_on ?
            ({{4{cfg.track_center_q4[15]}}, cfg.track_center_q4} + {{2{off[17]}}, off}) :
            $signed({6'b000000, cfg.image_width, 3'b000});
    w_n = e1.run_end - e1.run_start;
    c2_n = {1'b0, e1.run_start} + {1'b0, e1.run_end};

    diff = $signed({7'b0000000, c2_2, 3'b000}) - {exp2[19], exp2};
    mag = diff[20] ? 21'(-diff) : diff;

    take = v3 && ok3 && (d3 < best_distance_q4);
    nb_valid = best_valid || take;
    nb_center2 = take ? c2_3 : best_center2;
    nb_width = take ? w3 : best_width;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= q_event;
      prod1 <= q_event.dy_q4 * cfg.track_slope_q14;

      exp2 <= exp_n;
      c2_2 <= c2_n;
      w2 <= w_n;
      row2 <= e1.row;
      last2 <= e1.last;
      ok2 <= e1.has_run && (w_n >= rrlt_pkg::MIN_RUN_WIDTH) && (w_n <= cfg.max_run_width);

      d3 <= mag[19:0];
      c2_3 <= c2_2;
      w3 <= w2;
      row3 <= row2;
      last3 <= last2;
      ok3 <= ok2 && (!cfg.tracking_on ||
                     mag[19:0] <= {5'b00000, cfg.track_dist_limit, 4'b0000});

      if (v3 && last3) begin
        res.found <= nb_valid;
        res.center_x2 <= nb_valid ? nb_center2 : 11'd0;
        res.run_width <= nb_valid ? nb_width : 10'd0;
        res.row_out <= row3;
      end
      if (v3 && !last3 && take) begin
        best_center2 <= c2_3;
        best_width <= w3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      res_valid <= 1'b0;
      best_valid <= 1'b0;
      best_distance_q4 <= rrlt_pkg::DIST_NONE;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      res_valid <= v3 && last3;
      if (v3) begin
        if (last3) begin
          best_valid <= 1'b0;
          best_distance_q4 <= rrlt_pkg::DIST_NONE;
        end else if (take) begin
          best_valid <= 1'b1;
          best_distance_q4 <= d3;
        end
      end
    end
  end

endmodule

// ===== src/row_run_line_tracker_unit.sv =====
// Top level of the row run line tracker: configuration registers, front,
// event queue and back. Depends on rrlt_pkg, rrlt_front, rrlt_queue, rrlt_back.
//
// Usage: pixels enter row by row on the pix channel (pix_valid, pix_stall,
// pix). The last pixel of each row carries last_in_row. For every row the
// block sends one request on the res channel: found, the chosen run's start
// plus end (center_x2), its width and the row index.
// A request is taken at a rising edge where valid is high and stall is low.
// Throughput is one pixel per cycle while pix_stall is low. A row result
// reaches the result register after the row's last event has passed the event
// queue, then the product, expected-centre, distance and selection stages.
// The front emits at most one event per pixel, so the back keeps pace.
// When the receiver stalls, the back holds, the four-entry event queue fills,
// and only then does pix_stall rise; pixels without an event still need a
// free slot, so the front stops while the queue is full. Configuration is to
// be written through cfg_we, cfg_index and cfg_data only while the block is
// idle; the block does not enforce it. Synchronous reset loads the register
// defaults, empties queue and pipeline, and starts a fresh row at column zero.
module row_run_line_tracker_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  output logic           pix_stall,
  input  rrlt_pkg::pix_t pix,
  output logic           res_valid,
  input  logic           res_stall,
  output rrlt_pkg::res_t res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  rrlt_pkg::cfg_t cfg;

  logic push, q_full, q_pop, q_not_empty;
  rrlt_pkg::event_t push_event, q_head;

  // Configuration registers; each write keeps only the register's own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= rrlt_pkg::RST_IMAGE_WIDTH;
      cfg.image_height <= rrlt_pkg::RST_IMAGE_HEIGHT;
      cfg.border_margin <= rrlt_pkg::RST_BORDER_MARGIN;
      cfg.max_run_width <= rrlt_pkg::RST_MAX_RUN_WIDTH;
      cfg.tracking_on <= rrlt_pkg::RST_TRACKING_ON;
      cfg.track_center_q4 <= rrlt_pkg::RST_TRACK_CENTER_Q4;
      cfg.track_slope_q14 <= rrlt_pkg::RST_TRACK_SLOPE_Q14;
      cfg.track_dist_limit <= rrlt_pkg::RST_TRACK_DIST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        rrlt_pkg::CFG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_data[10:0];
        end
        rrlt_pkg::CFG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_data[10:0];
        end
        rrlt_pkg::CFG_BORDER_MARGIN: begin
          cfg.border_margin <= cfg_data[7:0];
        end
        rrlt_pkg::CFG_MAX_RUN_WIDTH: begin
          cfg.max_run_width <= cfg_data[9:0];
        end
        rrlt_pkg::CFG_TRACKING_ON: begin
          cfg.tracking_on <= cfg_data[0];
        end
        rrlt_pkg::CFG_TRACK_CENTER_Q4: begin
          cfg.track_center_q4 <= $signed(cfg_data);
        end
        rrlt_pkg::CFG_TRACK_SLOPE_Q14: begin
          cfg.track_slope_q14 <= $signed(cfg_data);
        end
        rrlt_pkg::CFG_TRACK_DIST_LIMIT: begin
          cfg.track_dist_limit <= cfg_data[10:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front classifies every pixel and turns run ends and row ends into events.
  rrlt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix),
    .q_full     (q_full),
    .push       (push),
    .push_event (push_event)
  );

  // The queue lets the front run on while the result side is stalled.
  rrlt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // The back scores each run against the expected centre and keeps the best.
  rrlt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_event   (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== src/rrlt_checker.sv =====
// Port-level checker of the row run line tracker and its bind statement.
// Depends on rrlt_pkg and row_run_line_tracker_unit_defines.svh.
`include "row_run_line_tracker_unit_defines.svh"

module rrlt_checker (
  input logic           clk,
  input logic           rst,
  input logic           pix_valid,
  input logic           pix_stall,
  input rrlt_pkg::pix_t pix,
  input logic           res_valid,
  input logic           res_stall,
  input rrlt_pkg::res_t res,
  input logic           cfg_we,
  input logic [2:0]     cfg_index,
  input logic [15:0]    cfg_data
);

  // A row without an accepted run reports zero centre and width.
  `RRLT_ASSERT_SAME(a_empty_row_zero, clk, rst, res_valid && !res.found, res.center_x2 == 11'd0 && res.run_width == 10'd0)

  // An accepted run is never narrower than the minimum width.
  `RRLT_ASSERT_SAME(a_found_min_width, clk, rst, res_valid && res.found, res.run_width >= rrlt_pkg::MIN_RUN_WIDTH)

  // Start plus end can never fall below end minus start.
  `RRLT_ASSERT_SAME(a_center_covers_width, clk, rst, res_valid && res.found, res.center_x2 >= {1'b0, res.run_width})

  // A stalled result request stays and holds its payload.
  `RRLT_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind row_run_line_tracker_unit rrlt_checker u_rrlt_checker (.*);

// ===== tb/sv/tb_row_run_line_tracker_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for row_run_line_tracker_unit: streams rows of pixels,
// predicts each row result in a small tracker class and compares field by field.
// Depends on rrlt_pkg and the RTL of row_run_line_tracker_unit.
module tb_row_run_line_tracker_unit;

  // Pixel budget for the whole run, the final long row included.
  localparam int TOTAL_ITEMS = 1550;
  // The final row runs past the column counter so that the count saturates.
  localparam int LONG_ROW_LEN = 1030;
  // The random part stops once this many pixels have gone in overall.
  localparam int RANDOM_ITEMS = TOTAL_ITEMS - LONG_ROW_LEN;
  // Waited after the last row result has come back; this gives the pipeline
  // ample room to settle before a register write.
  localparam int DRAIN_CYCLES = 12;
  // Time limit for the whole run, far beyond what a correct run needs.
  localparam int RUN_LIMIT_NS = 1_000_000;

  // Tracks runs of bright pixels across a row, exactly as the block should,
  // and keeps the row results that are due from the block in order.
  class line_run_tracker;
    // Register copies, loaded with the reset values.
    logic [10:0]        img_w = rrlt_pkg::RST_IMAGE_WIDTH;
    logic [10:0]        img_h = rrlt_pkg::RST_IMAGE_HEIGHT;
    logic [7:0]         margin = rrlt_pkg::RST_BORDER_MARGIN;
    logic [9:0]         max_w = rrlt_pkg::RST_MAX_RUN_WIDTH;
    logic               trk_on = rrlt_pkg::RST_TRACKING_ON;
    logic signed [15:0] trk_center = rrlt_pkg::RST_TRACK_CENTER_Q4;
    logic signed [15:0] trk_slope = rrlt_pkg::RST_TRACK_SLOPE_Q14;
    logic [10:0]        max_d = rrlt_pkg::RST_TRACK_DIST_LIMIT;

    // Per-row state.
    logic [9:0]         col;
    logic               run_open;
    logic [9:0]         run_start;
    logic               have_best;
    logic [10:0]        best_c2;
    logic [9:0]         best_w;
    logic [19:0]        best_d;
    logic signed [19:0] aim_q4;

    rrlt_pkg::res_t rows_due[$];
    int   errors = 0;

    function new();
      clear_row();
    endfunction

    function void clear_row();
      col = '0;
      run_open = 1'b0;
      run_start = '0;
      have_best = 1'b0;
      best_c2 = '0;
      best_w = '0;
      best_d = rrlt_pkg::DIST_NONE;
      aim_q4 = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        rrlt_pkg::CFG_IMAGE_WIDTH:      img_w = val[10:0];
        rrlt_pkg::CFG_IMAGE_HEIGHT:     img_h = val[10:0];
        rrlt_pkg::CFG_BORDER_MARGIN:    margin = val[7:0];
        rrlt_pkg::CFG_MAX_RUN_WIDTH:    max_w = val[9:0];
        rrlt_pkg::CFG_TRACKING_ON:      trk_on = val[0];
        rrlt_pkg::CFG_TRACK_CENTER_Q4:  trk_center = val;
        rrlt_pkg::CFG_TRACK_SLOPE_Q14:  trk_slope = val;
        rrlt_pkg::CFG_TRACK_DIST_LIMIT: max_d = val[10:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    // The margin is clamped to half the dimension minus one, never below zero.
    function int margin_of(int dim);
      int half;
      half = dim / 2 - 1;
      if (half < 0) half = 0;
      return (int'(margin) < half) ? int'(margin) : half;
    endfunction

    // Expected line column for a row in 1/16 pixel: the image middle, or the
    // tracked centre moved along the slope with round-to-nearest, ties rounded up.
    function logic signed [19:0] aim_for(logic [9:0] r);
      longint rr, hh, dy, prod;
      if (!trk_on) return 20'(int'(img_w) * 8);
      rr = r;
      hh = img_h;
      dy = rr * 16 - hh * 8;
      prod = dy * longint'(trk_slope) + rrlt_pkg::ROUND_Q14;
      return 20'(longint'(trk_center) + (prod >>> 14));
    endfunction

    function void close_run(int run_end);
      int st, w, c2, diff, d;
      st = run_start;
      if (run_end < st) return;
      w = run_end - st;
      if (w < int'(rrlt_pkg::MIN_RUN_WIDTH) || w > int'(max_w)) return;
      c2 = st + run_end;
      diff = c2 * 8 - int'(aim_q4);
      d = (diff < 0) ? -diff : diff;
      if (trk_on && d > int'(max_d) * 16) return;
      // Only a strictly closer run replaces the one held.
      if (d < int'(best_d)) begin
        best_d = 20'(d);
        best_c2 = 11'(c2);
        best_w = 10'(w);
        have_best = 1'b1;
      end
    endfunction

    function void take_pixel(rrlt_pkg::pix_t p);
      int   c, r, wd, ht, mx, my;
      bit   masked, is_line;
      rrlt_pkg::res_t due;
      c = col;
      r = p.row;
      wd = img_w;
      ht = img_h;
      mx = margin_of(wd);
      my = margin_of(ht);
      if (c == 0) aim_q4 = aim_for(p.row);
      masked = (c < mx) || (c >= wd - mx) || (r < my) || (r >= ht - my);
      is_line = !masked && (p.pixel > rrlt_pkg::LINE_LEVEL);
      if (is_line && !run_open) begin
        run_open = 1'b1;
        run_start = col;
      end else if (!is_line && run_open) begin
        run_open = 1'b0;
        close_run(c - 1);
      end
      if (!p.last_in_row) begin
        if (col != rrlt_pkg::COL_LAST) col++;
        return;
      end
      // A run still open at the row end closes on the last pixel.
      if (run_open) begin
        run_open = 1'b0;
        close_run(c);
      end
      due.found = have_best;
      due.center_x2 = have_best ? best_c2 : '0;
      due.run_width = have_best ? best_w : '0;
      due.row_out = p.row;
      rows_due = {rows_due, due};
      clear_row();
    endfunction

    task report(string what);
      errors++;
      $display("row check at %0t: %s", $realtime, what);
    endtask

    task check_row(rrlt_pkg::res_t got);
      rrlt_pkg::res_t want;
      if (rows_due.size() == 0) begin
        report($sformatf("result for row %0d with none due", got.row_out));
        return;
      end
      want = rows_due.pop_front();
      if (got.found !== want.found)
        report($sformatf("row %0d found %b, want %b", want.row_out, got.found, want.found));
      if (got.center_x2 !== want.center_x2)
        report($sformatf("row %0d center_x2 %0d, want %0d", want.row_out, got.center_x2,
                         want.center_x2));
      if (got.run_width !== want.run_width)
        report($sformatf("row %0d run_width %0d, want %0d", want.row_out, got.run_width,
                         want.run_width));
      if (got.row_out !== want.row_out)
        report($sformatf("row_out %0d, want %0d", got.row_out, want.row_out));
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst;
  logic           pix_valid;
  logic           pix_stall;
  rrlt_pkg::pix_t pix;
  logic           res_valid;
  logic           res_stall = 1'b0;
  rrlt_pkg::res_t res;
  logic           cfg_we;
  logic [2:0]     cfg_index;
  logic [15:0]    cfg_data;

  line_run_tracker tracker = new();

  // Sender pacing: bursts of requests separated by random gaps bounded by gap_max.
  // A gap_max of zero keeps the sender busy every cycle.
  int gap_max = 0;
  int burst_left = 0;
  int items_sent = 0;

  // Receiver stall pattern, switched between several kinds at random.
  typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_PERIODIC} stall_kind_e;
  stall_kind_e stall_kind = STALL_NONE;
  int          stall_left = 0;
  int          stall_hold = 0;
  logic        stall_level = 1'b0;

  row_run_line_tracker_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver changes its stall line on the falling edge only. Long stalls
  // back the event queue up until pix_stall rises, so every stage gets hit.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_kind = stall_kind_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      case (stall_kind)
        STALL_NONE: begin
          res_stall <= 1'b0;
        end
        STALL_COIN: begin
          res_stall <= 1'($urandom_range(0, 1));
        end
        STALL_LONG: begin
          if (stall_hold == 0) begin
            stall_hold = $urandom_range(1, 12);
            stall_level = !stall_level;
          end
          stall_hold--;
          res_stall <= stall_level;
        end
        default: begin
          res_stall <= (stall_left % 5) < 2;
        end
      endcase
    end
  end

  // Results are taken at the rising edge where valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_row(res);
  end

  // Offers one pixel request and holds it until the block takes it. Called on
  // a falling edge; returns on a falling edge after the hand-off and any gap.
  task automatic send_pixel(input rrlt_pkg::pix_t p);
    int gap;
    pix_valid <= 1'b1;
    pix <= p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    tracker.take_pixel(p);
    items_sent++;
    @(negedge clk);
    if (gap_max > 0) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, gap_max);
        pix_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // One row of alternating bright and dark stretches. Bright stretches lean
  // toward lengths around the minimum width and around max_run_width, so both
  // width gates are crossed often. A noisy row is random grey values instead.
  task automatic send_row(input logic [9:0] r, input int len, input bit noisy);
    rrlt_pkg::pix_t p;
    int   seg;
    int   run_max;
    bit   bright;
    seg = 0;
    bright = 1'($urandom_range(0, 1));
    run_max = int'(tracker.max_w) + 2;
    for (int i = 0; i < len; i++) begin
      if (seg == 0) begin
        bright = !bright;
        if (bright) begin
          case ($urandom_range(0, 3))
            0: seg = $urandom_range(4, 8);
            1: seg = $urandom_range(1, run_max);
            2: seg = $urandom_range(1, len);
            default: seg = $urandom_range(1, 3);
          endcase
        end else begin
          seg = $urandom_range(1, 10);
        end
      end
      seg--;
      if (noisy) begin
        p.pixel = 8'($urandom_range(0, 255));
      end else if (bright) begin
        case ($urandom_range(0, 3))
          0: p.pixel = 8'd128;
          1: p.pixel = 8'd255;
          default: p.pixel = 8'($urandom_range(128, 255));
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: p.pixel = 8'd127;
          1: p.pixel = 8'd0;
          default: p.pixel = 8'($urandom_range(0, 127));
        endcase
      end
      p.row = r;
      p.last_in_row = (i == len - 1);
      send_pixel(p);
    end
  endtask

  // Waits until every row result has come back, then lets the pipeline settle.
  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes one register on the next rising edge; the caller lowers cfg_we.
  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  initial begin
    rrlt_pkg::pix_t p;
    int   phase, rows, top, len, wd;
    int   w, h, m, mw, tc, ts, td;
    bit   trk, write_all;

    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);

    // Directed: a row under the reset registers. The first fifteen columns are
    // border, so the bright stretch opens at column 15 and is still open at the
    // row end, which closes it on the last pixel. The darkest and the two
    // values either side of the threshold sit in the border.
    for (int i = 0; i < 21; i++) begin
      case (i)
        0: p.pixel = 8'd0;
        1: p.pixel = 8'd127;
        2: p.pixel = 8'd128;
        default: p.pixel = 8'd255;
      endcase
      p.row = 10'd240;
      p.last_in_row = (i == 20);
      send_pixel(p);
    end

    // Directed: a tracked centre exactly between two runs of equal width, so
    // the first one must win the tie; the second is open at the row end.
    wait_drained();
    put_reg(rrlt_pkg::CFG_IMAGE_WIDTH, 16'd16);
    put_reg(rrlt_pkg::CFG_IMAGE_HEIGHT, 16'd16);
    put_reg(rrlt_pkg::CFG_BORDER_MARGIN, 16'd0);
    put_reg(rrlt_pkg::CFG_MAX_RUN_WIDTH, 16'd1023);
    put_reg(rrlt_pkg::CFG_TRACKING_ON, 16'd1);
    put_reg(rrlt_pkg::CFG_TRACK_CENTER_Q4, 16'd96);
    put_reg(rrlt_pkg::CFG_TRACK_SLOPE_Q14, 16'd0);
    put_reg(rrlt_pkg::CFG_TRACK_DIST_LIMIT, 16'd2047);
    cfg_we <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < 13; i++) begin
      p.pixel = (i == 6) ? 8'd0 : 8'd255;
      p.row = 10'd8;
      p.last_in_row = (i == 12);
      send_pixel(p);
    end
    // Directed: a one-pixel row at the highest row index, below the image.
    p.pixel = 8'd255;
    p.row = 10'd1023;
    p.last_in_row = 1'b1;
    send_pixel(p);

    // Random phases. The first two write every register, mostly with low values,
    // then with high ones; later phases mix extremes with values near the runs.
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      case (phase)
        0: begin
          w = 16; h = 16; m = 0; mw = 0; trk = 1'b0;
          tc = -16384; ts = -32768; td = 0;
        end
        1: begin
          w = 1024; h = 1024; m = $urandom_range(0, 8); mw = 1023; trk = 1'b1;
          tc = 32767; ts = 32767; td = 2047;
        end
        default: begin
          w = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(16, 48);
          case ($urandom_range(0, 3))
            0: h = 16;
            1: h = 1024;
            default: h = $urandom_range(16, 64);
          endcase
          case ($urandom_range(0, 4))
            0: m = 0;
            1: m = 255;
            2: m = $urandom_range(0, 255);
            default: m = $urandom_range(0, 6);
          endcase
          case ($urandom_range(0, 3))
            0: mw = 1023;
            1: mw = $urandom_range(0, 1023);
            default: mw = $urandom_range(4, w);
          endcase
          trk = phase[0];
          if ($urandom_range(0, 7) == 0) tc = int'($urandom_range(0, 49151)) - 16384;
          else tc = $urandom_range(0, w * 16);
          case ($urandom_range(0, 5))
            0: ts = 0;
            1: ts = -32768;
            2: ts = 32767;
            3: ts = int'($urandom_range(0, 65535)) - 32768;
            default: ts = int'($urandom_range(0, 8192)) - 4096;
          endcase
          case ($urandom_range(0, 3))
            0: td = 0;
            1: td = 2047;
            default: td = $urandom_range(0, w);
          endcase
        end
      endcase
      // Later phases leave some registers as they were.
      write_all = (phase < 2);
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_IMAGE_WIDTH, 16'(w));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_IMAGE_HEIGHT, 16'(h));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_BORDER_MARGIN, 16'(m));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_MAX_RUN_WIDTH, 16'(mw));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_TRACKING_ON, 16'(trk));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_TRACK_CENTER_Q4, 16'(tc));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_TRACK_SLOPE_Q14, 16'(ts));
      if (write_all || $urandom_range(0, 3) != 0)
        put_reg(rrlt_pkg::CFG_TRACK_DIST_LIMIT, 16'(td));
      cfg_we <= 1'b0;
      @(negedge clk);

      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = 0;
      rows = $urandom_range(3, 9);
      for (int k = 0; k < rows; k++) begin
        top = int'(tracker.img_h) + 3;
        if (top > 1023) top = 1023;
        wd = tracker.img_w;
        // Wide images get short rows; otherwise rows mostly match the width,
        // sometimes running short or past the last column.
        if (wd > 64) len = $urandom_range(8, 60);
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, wd + 10);
        else len = wd;
        send_row(10'($urandom_range(0, top)), len, $urandom_range(0, 4) == 0);
      end
      phase++;
    end

    // One row longer than the column counter, so the count saturates and the
    // last pixels share the final column.
    wait_drained();
    put_reg(rrlt_pkg::CFG_IMAGE_WIDTH, 16'd1024);
    put_reg(rrlt_pkg::CFG_IMAGE_HEIGHT, 16'd1024);
    put_reg(rrlt_pkg::CFG_BORDER_MARGIN, 16'($urandom_range(0, 3)));
    put_reg(rrlt_pkg::CFG_MAX_RUN_WIDTH, 16'd1023);
    put_reg(rrlt_pkg::CFG_TRACKING_ON, 16'd0);
    cfg_we <= 1'b0;
    @(negedge clk);
    gap_max = 0;
    send_row(10'($urandom_range(8, 1015)), LONG_ROW_LEN, 1'b0);

    wait_drained();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("row_run_line_tracker_unit: match");
    end else begin
      $display("row_run_line_tracker_unit: mismatch");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("row_run_line_tracker_unit: mismatch");
    $finish;
  end

endmodule
